@@ src/esc_utf8_pkg.sv @@
// Shared types, character codes and helpers for the backslash escape decoder.
// No dependencies; used by esc_utf8_scan and escape_unescape_to_utf8_top.
`default_nettype none

package esc_utf8_pkg;

    // Most result bytes one input byte can cause (\U flush, seven digits, one byte)
    localparam int MaxResults = 10;
    // Raw hex digits kept for a flush
    localparam int NumHeld    = 8;

    // Scan phases
    localparam logic [1:0] PHASE_NORMAL = 2'd0;
    localparam logic [1:0] PHASE_SLASH  = 2'd1;
    localparam logic [1:0] PHASE_HEX    = 2'd2;

    // escape_mode values
    localparam logic MODE_IRI    = 1'b0;
    localparam logic MODE_STRING = 1'b1;

    // Character codes
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // One result byte with its malformed-escape flag
    typedef struct packed {
        logic [7:0] data;
        logic       bad;
    } res_t;

    // All results of one input byte; entry 0 goes out first
    typedef struct packed {
        res_t [MaxResults-1:0] ent;
        logic [3:0]            cnt;
        logic                  last;
    } burst_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // ASCII hex digit to nibble, ok low for anything else
    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t r;
        r = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            r.ok    = 1'b1;
            r.value = 4'(b - CH_ZERO);
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            r.ok    = 1'b1;
            r.value = 4'(b - CH_UPPER_A + 8'd10);
        end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
            r.ok    = 1'b1;
            r.value = 4'(b - CH_LOWER_A + 8'd10);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/esc_utf8_scan.sv @@
// Escape scanner: scan state, held hex digits, mode register and the decode
// of one byte into its burst of results. Depends on esc_utf8_pkg.
`default_nettype none

module esc_utf8_scan (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  step,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    output esc_utf8_pkg::burst_t       burst
);
    import esc_utf8_pkg::*;

    logic              mode_reg;
    logic [1:0]        phase_reg, phase_next;
    logic              wide_reg, wide_next;
    logic [2:0]        digits_reg, digits_next;
    logic [31:0]       code_reg, code_next;
    logic [7:0]        held_reg [NumHeld];
    logic [7:0]        held_view [NumHeld];
    logic              held_we;

    hex_t              hexd;
    logic [31:0]       cp;
    logic [3:0]        dig_inc;
    logic              as_text;
    logic [3:0]        n;
    burst_t            res;

    // Held digits as seen after this byte's digit is stored
    always_comb begin
        for (int i = 0; i < NumHeld; i++) begin
            held_view[i] = (3'(i) == digits_reg) ? in_byte : held_reg[i];
        end
    end

    // Decode of one byte; a flush always opens the list, so it uses fixed slots
    always_comb begin
        phase_next  = phase_reg;
        wide_next   = wide_reg;
        digits_next = digits_reg;
        code_next   = code_reg;
        held_we     = 1'b0;
        as_text     = 1'b0;
        n           = '0;
        res         = '0;
        hexd        = hex_decode(in_byte);
        cp          = {code_reg[27:0], hexd.value};
        dig_inc     = {1'b0, digits_reg} + 4'd1;

        case (phase_reg)
            PHASE_SLASH: begin
                phase_next = PHASE_NORMAL;
                if (in_byte == CH_LOWER_U || in_byte == CH_UPPER_U) begin
                    phase_next  = PHASE_HEX;
                    wide_next   = (in_byte == CH_UPPER_U);
                    digits_next = '0;
                    code_next   = '0;
                end else if (in_byte == CH_BSLASH) begin
                    res.ent[n] = '{data: CH_BSLASH, bad: 1'b0};
                    n = n + 4'd1;
                end else if (mode_reg == MODE_STRING && in_byte == CH_LOWER_T) begin
                    res.ent[n] = '{data: CH_TAB, bad: 1'b0};
                    n = n + 4'd1;
                end else if (mode_reg == MODE_STRING && in_byte == CH_LOWER_N) begin
                    res.ent[n] = '{data: CH_LF, bad: 1'b0};
                    n = n + 4'd1;
                end else if (mode_reg == MODE_STRING && in_byte == CH_LOWER_R) begin
                    res.ent[n] = '{data: CH_CR, bad: 1'b0};
                    n = n + 4'd1;
                end else if (mode_reg == MODE_STRING && in_byte == CH_QUOTE) begin
                    res.ent[n] = '{data: CH_QUOTE, bad: 1'b0};
                    n = n + 4'd1;
                end else if (mode_reg == MODE_IRI && in_byte == CH_GT) begin
                    res.ent[n] = '{data: CH_GT, bad: 1'b0};
                    n = n + 4'd1;
                end else begin
                    // unknown escape passes through
                    res.ent[n] = '{data: CH_BSLASH, bad: 1'b0};
                    n = n + 4'd1;
                    res.ent[n] = '{data: in_byte, bad: 1'b0};
                    n = n + 4'd1;
                end
            end
            PHASE_HEX: begin
                if (hexd.ok) begin
                    held_we = 1'b1;
                    if (dig_inc >= (wide_reg ? 4'd8 : 4'd4)) begin
                        // complete value: UTF-8 encode
                        phase_next  = PHASE_NORMAL;
                        digits_next = '0;
                        code_next   = '0;
                        if (cp <= 32'h7F) begin
                            res.ent[n] = '{data: cp[7:0], bad: 1'b0};
                            n = n + 4'd1;
                        end else if (cp <= 32'h7FF) begin
                            res.ent[n] = '{data: {3'b110, cp[10:6]}, bad: 1'b0};
                            n = n + 4'd1;
                            res.ent[n] = '{data: {2'b10, cp[5:0]}, bad: 1'b0};
                            n = n + 4'd1;
                        end else if (cp <= 32'hFFFF) begin
                            res.ent[n] = '{data: {4'b1110, cp[15:12]}, bad: 1'b0};
                            n = n + 4'd1;
                            res.ent[n] = '{data: {2'b10, cp[11:6]}, bad: 1'b0};
                            n = n + 4'd1;
                            res.ent[n] = '{data: {2'b10, cp[5:0]}, bad: 1'b0};
                            n = n + 4'd1;
                        end else if (cp <= 32'h10FFFF) begin
                            res.ent[n] = '{data: {5'b11110, cp[20:18]}, bad: 1'b0};
                            n = n + 4'd1;
                            res.ent[n] = '{data: {2'b10, cp[17:12]}, bad: 1'b0};
                            n = n + 4'd1;
                            res.ent[n] = '{data: {2'b10, cp[11:6]}, bad: 1'b0};
                            n = n + 4'd1;
                            res.ent[n] = '{data: {2'b10, cp[5:0]}, bad: 1'b0};
                            n = n + 4'd1;
                        end else begin
                            // out of range: one flagged empty result
                            res.ent[n] = '{data: CH_NUL, bad: 1'b1};
                            n = n + 4'd1;
                        end
                    end else begin
                        digits_next = dig_inc[2:0];
                        code_next   = cp;
                    end
                end else begin
                    // malformed: flush what was held, then treat byte as text
                    res.ent[0] = '{data: CH_BSLASH, bad: 1'b1};
                    res.ent[1] = '{data: (wide_reg ? CH_UPPER_U : CH_LOWER_U), bad: 1'b1};
                    for (int i = 0; i < NumHeld; i++) begin
                        if (3'(i) < digits_reg) begin
                            res.ent[i+2] = '{data: held_view[i], bad: 1'b1};
                        end
                    end
                    n           = 4'd2 + {1'b0, digits_reg};
                    phase_next  = PHASE_NORMAL;
                    digits_next = '0;
                    code_next   = '0;
                    as_text     = 1'b1;
                end
            end
            default: begin
                phase_next = PHASE_NORMAL;
                as_text    = 1'b1;
            end
        endcase

        // plain text byte
        if (as_text) begin
            if (in_byte == CH_BSLASH) begin
                phase_next = PHASE_SLASH;
            end else begin
                res.ent[n] = '{data: in_byte, bad: 1'b0};
                n = n + 4'd1;
            end
        end

        // end of text: flush a pending escape and return to normal
        if (in_last) begin
            if (phase_next == PHASE_SLASH) begin
                res.ent[n] = '{data: CH_BSLASH, bad: 1'b1};
                n = n + 4'd1;
            end else if (phase_next == PHASE_HEX) begin
                res.ent[0] = '{data: CH_BSLASH, bad: 1'b1};
                res.ent[1] = '{data: (wide_next ? CH_UPPER_U : CH_LOWER_U), bad: 1'b1};
                for (int i = 0; i < NumHeld; i++) begin
                    if (3'(i) < digits_next) begin
                        res.ent[i+2] = '{data: held_view[i], bad: 1'b1};
                    end
                end
                n = 4'd2 + {1'b0, digits_next};
            end
            phase_next  = PHASE_NORMAL;
            wide_next   = 1'b0;
            digits_next = '0;
            code_next   = '0;
        end

        res.cnt  = n;
        res.last = in_last;
        burst    = res;
    end

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_STRING;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_NORMAL;
            wide_reg   <= 1'b0;
            digits_reg <= '0;
            code_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            wide_reg   <= wide_next;
            digits_reg <= digits_next;
            code_reg   <= code_next;
        end
    end

    // Held digit store, no reset
    always_ff @(posedge aclk) begin
        if (step && held_we) begin
            held_reg[digits_reg] <= in_byte;
        end
    end

    // Digits are only counted inside a numeric escape
    a_digits_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PHASE_HEX) |-> (digits_reg == '0))
        else $error("digit count left over outside a numeric escape");

    // A short escape never holds four digits
    a_short_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PHASE_HEX && !wide_reg) |-> (digits_reg < 3'd4))
        else $error("short escape holds too many digits");

endmodule

`default_nettype wire

@@ src/escape_unescape_to_utf8_top.sv @@
// Top level of the backslash escape decoder with UTF-8 output.
// Depends on esc_utf8_pkg and esc_utf8_scan.
`default_nettype none

// Decodes backslash escapes in a byte stream. One input byte is decoded in
// the cycle it is accepted and its results (zero to ten bytes) are loaded
// into a burst register, which feeds the output register one byte per cycle
// unless the output stalls. The next byte is taken when the burst is empty
// or in the cycle its last result moves to the output register, so plain
// text runs at one byte per cycle unless the output stalls; the output
// port's one byte per transfer sets this rate. escape_mode is written
// through cfg_wr_en/cfg_wr_data and resets to string mode.
module escape_unescape_to_utf8_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,   // escape_mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] in_byte
    input  wire logic       s_tlast,       // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_byte
    output logic            m_tlast,       // out_last
    output logic            m_tuser        // [0] bad_escape
);
    import esc_utf8_pkg::*;

    burst_t                 burst;
    res_t [MaxResults-1:0]  bent_reg;
    logic [3:0]             bcnt_reg;
    logic                   blast_reg;
    logic                   s_accept;
    logic                   out_load;
    logic                   m_valid_reg;
    res_t                   m_data_reg;
    logic                   m_last_reg;

    esc_utf8_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (s_accept),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .burst       (burst)
    );

    // Handshake control
    assign out_load = (bcnt_reg != '0) && (!m_valid_reg || m_tready);
    assign s_tready = (bcnt_reg == '0) || (bcnt_reg == 4'd1 && out_load);
    assign s_accept = s_tvalid && s_tready;

    // Burst register: load on transfer in, shift down as bytes leave
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcnt_reg <= '0;
        end else if (s_accept) begin
            bcnt_reg <= burst.cnt;
        end else if (out_load) begin
            bcnt_reg <= bcnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bent_reg  <= burst.ent;
            blast_reg <= burst.last;
        end else if (out_load) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                bent_reg[i] <= bent_reg[i+1];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= bent_reg[0];
            m_last_reg <= blast_reg && (bcnt_reg == 4'd1);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg.data;
    assign m_tuser  = m_data_reg.bad;
    assign m_tlast  = m_last_reg;

    // Burst never holds more than the worst case
    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= 4'(MaxResults))
        else $error("burst count beyond capacity");

    // A new byte is only taken once the previous burst is drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (bcnt_reg == '0 || out_load))
        else $error("burst overwritten before its results left");

    // Reset empties both the burst and the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && bcnt_reg == '0))
        else $error("results left after reset");

endmodule

`default_nettype wire

@@ dv/esc_utf8_checker.sv @@
// Watches both streams of the escape decoder, predicts the decoded bytes and compares them.
// Depends on esc_utf8_pkg for scan phases, mode values and character codes.

module esc_utf8_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       m_tuser,
    output int         mismatches,
    output int         awaited
);
    import esc_utf8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } decoded_t;

    decoded_t    decoded_q[$];   // bytes still due on the output
    decoded_t    burst_q[$];     // bytes caused by the current input byte

    logic        mode;
    logic [1:0]  phase;
    logic        wide;
    logic [3:0]  ndig;
    logic [31:0] code;
    logic [7:0]  held [NumHeld];

    initial begin
        mismatches = 0;
        awaited    = 0;
    end

    function automatic void emit(input logic [7:0] d, input logic b);
        decoded_t r;
        r.data = d;
        r.last = 1'b0;
        r.bad  = b;
        burst_q.insert(burst_q.size(), r);
    endfunction

    // Raw bytes of an unfinished numeric escape, all flagged
    function automatic void flush_numeric();
        emit(CH_BSLASH, 1'b1);
        emit(wide ? CH_UPPER_U : CH_LOWER_U, 1'b1);
        for (int i = 0; i < ndig && i < NumHeld; i++)
            emit(held[i], 1'b1);
    endfunction

    function automatic void clear_escape();
        phase = PHASE_NORMAL;
        ndig  = '0;
        code  = '0;
    endfunction

    // Decoded bytes for one accepted input byte, appended to the queue
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic as_text;
        int   nib;
        as_text = 1'b0;
        burst_q.delete();
        case (phase)
            PHASE_SLASH: begin
                phase = PHASE_NORMAL;
                if (b == CH_LOWER_U || b == CH_UPPER_U) begin
                    phase = PHASE_HEX;
                    wide  = (b == CH_UPPER_U);
                    ndig  = '0;
                    code  = '0;
                end else if (b == CH_BSLASH)
                    emit(CH_BSLASH, 1'b0);
                else if (mode == MODE_STRING && b == CH_LOWER_T)
                    emit(CH_TAB, 1'b0);
                else if (mode == MODE_STRING && b == CH_LOWER_N)
                    emit(CH_LF, 1'b0);
                else if (mode == MODE_STRING && b == CH_LOWER_R)
                    emit(CH_CR, 1'b0);
                else if (mode == MODE_STRING && b == CH_QUOTE)
                    emit(CH_QUOTE, 1'b0);
                else if (mode == MODE_IRI && b == CH_GT)
                    emit(CH_GT, 1'b0);
                else begin
                    // unknown escape goes through as it stands
                    emit(CH_BSLASH, 1'b0);
                    emit(b, 1'b0);
                end
            end
            PHASE_HEX: begin
                nib = -1;
                if (b >= CH_ZERO && b <= CH_NINE)
                    nib = b - CH_ZERO;
                else if (b >= CH_UPPER_A && b <= CH_UPPER_F)
                    nib = b - CH_UPPER_A + 10;
                else if (b >= CH_LOWER_A && b <= CH_LOWER_F)
                    nib = b - CH_LOWER_A + 10;
                if (nib >= 0) begin
                    held[ndig[2:0]] = b;
                    code = {code[27:0], 4'(nib)};
                    ndig = ndig + 4'd1;
                    if (ndig >= (wide ? 4'd8 : 4'd4)) begin
                        // UTF-8 of the collected value
                        if (code <= 32'h7F)
                            emit(code[7:0], 1'b0);
                        else if (code <= 32'h7FF) begin
                            emit({3'b110, code[10:6]}, 1'b0);
                            emit({2'b10, code[5:0]}, 1'b0);
                        end else if (code <= 32'hFFFF) begin
                            emit({4'b1110, code[15:12]}, 1'b0);
                            emit({2'b10, code[11:6]}, 1'b0);
                            emit({2'b10, code[5:0]}, 1'b0);
                        end else if (code <= 32'h10FFFF) begin
                            emit({5'b11110, code[20:18]}, 1'b0);
                            emit({2'b10, code[17:12]}, 1'b0);
                            emit({2'b10, code[11:6]}, 1'b0);
                            emit({2'b10, code[5:0]}, 1'b0);
                        end else
                            emit(CH_NUL, 1'b1);
                        clear_escape();
                    end
                end else begin
                    // non-hex byte: flush, then treat it as text
                    flush_numeric();
                    clear_escape();
                    as_text = 1'b1;
                end
            end
            default: begin
                phase   = PHASE_NORMAL;
                as_text = 1'b1;
            end
        endcase

        if (as_text) begin
            if (b == CH_BSLASH)
                phase = PHASE_SLASH;
            else
                emit(b, 1'b0);
        end

        // end of text closes any open escape
        if (fin) begin
            if (phase == PHASE_SLASH)
                emit(CH_BSLASH, 1'b1);
            else if (phase == PHASE_HEX)
                flush_numeric();
            clear_escape();
            wide = 1'b0;
            if (burst_q.size() > 0)
                burst_q[burst_q.size() - 1].last = 1'b1;
        end

        decoded_q = {decoded_q, burst_q};
    endfunction

    function automatic void report(input string why, input decoded_t want,
                                   input decoded_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected data %02h last %0b bad %0b, got data %02h last %0b bad %0b",
                     $time, why, want.data, want.last, want.bad,
                     got.data, got.last, got.bad);
    endfunction

    // Prediction on input transfers, comparison on output transfers
    always @(posedge aclk) begin
        decoded_t got;
        decoded_t want;
        if (!aresetn) begin
            mode  = MODE_STRING;
            wide  = 1'b0;
            clear_escape();
            foreach (held[i])
                held[i] = '0;
            decoded_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.data = m_tdata;
                got.last = m_tlast;
                got.bad  = m_tuser;
                if (decoded_q.size() == 0)
                    report("unexpected transfer", '0, got);
                else begin
                    want = decoded_q.pop_front();
                    if (want.data != got.data || want.last != got.last
                            || want.bad != got.bad)
                        report("mismatch", want, got);
                end
            end
            if (cfg_wr_en)
                mode = cfg_wr_data;
        end
        awaited = decoded_q.size();
    end

endmodule

@@ dv/testbench.sv @@
// Stimulus and verdict for the escape decoder; esc_utf8_checker does the checking.
// Depends on esc_utf8_pkg, escape_unescape_to_utf8_top and esc_utf8_checker.

module testbench;
    import esc_utf8_pkg::*;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = '0;
    logic       s_tlast     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int mismatches;
    int awaited;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served        = 0;
    int hold_left          = 0;
    int bytes_sent         = 0;

    always #5 aclk = ~aclk;

    escape_unescape_to_utf8_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    esc_utf8_checker decode_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .awaited     (awaited)
    );

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = 200;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else
            m_tready = ($urandom_range(99) >= receiver_stall_pct);
    end

    // Hard limit on run length
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_ZERO + 8'(nib);
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        bytes_sent++;
    endtask

    task automatic send_text(input string txt, input logic fin);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], fin && i == txt.len() - 1);
    endtask

    // Let the block drain fully before touching the register
    task automatic settle();
        s_tvalid = 1'b0;
        while (awaited != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic set_mode(input logic m);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // One random piece of text: mostly well-formed escapes, some noise
    task automatic send_token(input logic fin);
        logic [31:0] cp;
        logic [7:0]  nb;
        int          kind;
        int          width;
        int          k;
        kind = $urandom_range(99);
        if (kind < 25)
            send_byte(8'($urandom_range(255)), fin);
        else if (kind < 45) begin
            // single-character escape, known in one mode or unknown
            send_byte(CH_BSLASH, 1'b0);
            case ($urandom_range(7))
                0: nb = CH_LOWER_T;
                1: nb = CH_LOWER_N;
                2: nb = CH_LOWER_R;
                3: nb = CH_QUOTE;
                4: nb = CH_GT;
                5: nb = CH_BSLASH;
                default: nb = 8'($urandom_range(255));
            endcase
            send_byte(nb, fin);
        end else if (kind < 80) begin
            // complete numeric escape over every UTF-8 length
            width = $urandom_range(1) ? 8 : 4;
            case ($urandom_range(width == 8 ? 4 : 2))
                0: cp = $urandom_range(32'h7F);
                1: cp = $urandom_range(32'h7FF, 32'h80);
                2: cp = $urandom_range(32'hFFFF, 32'h800);
                3: cp = $urandom_range(32'h10FFFF, 32'h10000);
                default: cp = $urandom_range(32'hFFFFFFFF, 32'h110000);
            endcase
            send_byte(CH_BSLASH, 1'b0);
            send_byte(width == 8 ? CH_UPPER_U : CH_LOWER_U, 1'b0);
            for (k = width - 1; k >= 0; k--)
                send_byte(hex_char(cp[4*k +: 4]), fin && k == 0);
        end else if (kind < 92) begin
            // numeric escape broken by a non-hex byte
            width = $urandom_range(1) ? 8 : 4;
            send_byte(CH_BSLASH, 1'b0);
            send_byte(width == 8 ? CH_UPPER_U : CH_LOWER_U, 1'b0);
            for (k = $urandom_range(width - 1); k > 0; k--)
                send_byte(hex_char(4'($urandom_range(15))), 1'b0);
            do
                nb = 8'($urandom_range(255));
            while ((nb >= CH_ZERO && nb <= CH_NINE) || (nb >= CH_UPPER_A && nb <= CH_UPPER_F)
                   || (nb >= CH_LOWER_A && nb <= CH_LOWER_F));
            send_byte(nb, fin);
        end else begin
            // text ends inside an escape
            width = $urandom_range(2);
            send_byte(CH_BSLASH, width == 0);
            if (width != 0) begin
                k = $urandom_range(width == 2 ? 7 : 3);
                send_byte(width == 2 ? CH_UPPER_U : CH_LOWER_U, k == 0);
                for (; k > 0; k--)
                    send_byte(hex_char(4'($urandom_range(15))), k == 1);
            end
        end
    endtask

    task automatic run_phase(input logic m, input int snd, input int rcv,
                             input bit squeeze, input int quota);
        int start;
        set_mode(m);
        sender_idle_pct    = snd;
        receiver_stall_pct = rcv;
        if (squeeze)
            hold_requests++;
        start = bytes_sent;
        while (bytes_sent - start < quota)
            send_token($urandom_range(7) == 0);
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: byte extremes, string escapes, surrogate, over-range,
        // broken and truncated escapes, then the IRI escapes
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\\t\\uD800\\UFFFFFFFF\\u1g", 1'b0);
        send_byte(CH_BSLASH, 1'b1);
        set_mode(MODE_IRI);
        send_text("\\>\\\\", 1'b1);

        // Random phases across both modes and idling patterns
        run_phase(MODE_IRI,    0,  0,  1'b0, 43);
        run_phase(MODE_STRING, 64, 0,  1'b0, 43);
        run_phase(MODE_IRI,    0,  64, 1'b0, 43);
        run_phase(MODE_STRING, 38, 38, 1'b0, 43);
        run_phase(MODE_IRI,    0,  0,  1'b1, 43);
        run_phase(MODE_STRING, 0,  0,  1'b1, 43);

        settle();
        if (mismatches == 0 && awaited == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
src/esc_utf8_pkg.sv
src/esc_utf8_scan.sv
src/escape_unescape_to_utf8_top.sv
dv/esc_utf8_checker.sv
dv/testbench.sv
